// ===== rtl/dnc_pkg.sv =====
package dnc_pkg;

    // Default number of stack places; the deepest usable nesting is one less.
    localparam int DNC_STACK_DEPTH = 256;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // Kind of an open nesting level.
    typedef logic [1:0] dnc_kind_t;

    localparam dnc_kind_t KIND_NONE   = 2'd0;
    localparam dnc_kind_t KIND_PARENS = 2'd1;
    localparam dnc_kind_t KIND_BRACES = 2'd2;
    localparam dnc_kind_t KIND_QUOTES = 2'd3;

    // Verdict causes.
    typedef logic [2:0] dnc_cause_t;

    localparam dnc_cause_t CAUSE_NEWLINE  = 3'd0;
    localparam dnc_cause_t CAUSE_END      = 3'd1;
    localparam dnc_cause_t CAUSE_COMMENT  = 3'd2;
    localparam dnc_cause_t CAUSE_SLASH    = 3'd3;
    localparam dnc_cause_t CAUSE_BRACE    = 3'd4;
    localparam dnc_cause_t CAUSE_EQUALS   = 3'd5;
    localparam dnc_cause_t CAUSE_OVERFLOW = 3'd6;

    // Shift command broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } dnc_shift_t;

endpackage

// ===== rtl/dnc_cell.sv =====
module dnc_cell
    import dnc_pkg::*;
(
    input  logic       clk,
    input  dnc_shift_t shift,
    input  dnc_kind_t  upper_kind,
    input  dnc_kind_t  lower_kind,
    output dnc_kind_t  kind
);

    dnc_kind_t kind_reg;
    dnc_kind_t kind_next;

    // A push moves every entry one place deeper, a pop one place up.
    always_comb
    begin
        priority if (shift.push)
        begin
            kind_next = upper_kind;
        end
        else if (shift.pop)
        begin
            kind_next = lower_kind;
        end
        else
        begin
            kind_next = kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

// ===== rtl/declaration_nesting_checker.sv =====
// Declaration nesting checker. The block takes source text one byte per item
// (0 marks the end of the text) and decides whether a declaration ends without
// a body. Parentheses, braces and double-quoted strings are tracked on a stack
// that holds up to STACK_DEPTH-1 open levels; a push beyond that rejects with
// the overflow cause. The end of text accepts at any depth; at top level a
// newline accepts, while an open brace or '=' rejects; a slash is decided by
// the byte after it (a second slash accepts as a line comment, anything else
// rejects). Inside quotes a backslash escapes a quote. Each verdict is one item
// on the verdict channel, and after it all nesting state returns to its reset
// value, so the next byte starts a new declaration. The block takes one byte in
// every clock cycle while text_ready is high: the stack is a row of cells that
// all shift together, so a push or a pop finishes in the cycle in which its
// byte is accepted. A verdict sits in an output register backed by a one-entry
// skid register; text_ready drops only while the skid register holds a verdict
// that the consumer has not yet taken. Stack contents are not cleared at reset
// or after a verdict, since an entry is read only after it has been pushed.
module declaration_nesting_checker
    import dnc_pkg::*;
#(
    parameter int STACK_DEPTH = DNC_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    output logic       verdict_valid,
    input  logic       verdict_ready,
    output logic       accepted,
    output logic [2:0] cause
);

    // One cell per usable stack level; cell 0 is the top of the stack.
    localparam int NUM_CELLS = STACK_DEPTH - 1;
    localparam int DEPTH_W   = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH - 1);

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               slash_pending_reg;
    logic               slash_pending_next;
    // Only whether the previous byte was an unescaped backslash matters.
    logic               prev_bs_reg;
    logic               prev_bs_next;

    logic               out_valid_reg;
    logic               accepted_reg;
    dnc_cause_t         cause_reg;
    logic               skid_valid_reg;
    logic               skid_accepted_reg;
    dnc_cause_t         skid_cause_reg;

    logic               text_fire;
    logic               out_free;
    dnc_kind_t          top_kind;
    logic               stack_full;
    logic               push_want;
    dnc_kind_t          push_kind;
    logic               pop_want;
    logic               res_valid;
    logic               res_accepted;
    dnc_cause_t         res_cause;
    dnc_shift_t         shift;
    dnc_kind_t          cell_kind [NUM_CELLS];

    assign text_ready = !skid_valid_reg;
    assign text_fire  = text_valid && text_ready;
    assign out_free   = !out_valid_reg || verdict_ready;

    assign top_kind   = (depth_reg != '0) ? cell_kind[0] : KIND_NONE;
    assign stack_full = (depth_reg >= DEPTH_FULL);

    // Decode one byte against the current context.
    always_comb
    begin
        push_want          = 1'b0;
        push_kind          = KIND_NONE;
        pop_want           = 1'b0;
        res_valid          = 1'b0;
        res_accepted       = 1'b0;
        res_cause          = CAUSE_NEWLINE;
        slash_pending_next = slash_pending_reg;
        prev_bs_next       = prev_bs_reg;

        priority if (slash_pending_reg)
        begin
            res_valid    = 1'b1;
            res_accepted = (text_byte == CH_SLASH);
            res_cause    = (text_byte == CH_SLASH) ? CAUSE_COMMENT : CAUSE_SLASH;
        end
        else if (text_byte == CH_END)
        begin
            res_valid    = 1'b1;
            res_accepted = 1'b1;
            res_cause    = CAUSE_END;
        end
        else
        begin
            unique case (top_kind)
                KIND_NONE:
                begin
                    priority if (text_byte == CH_LPAREN)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_PARENS;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_QUOTES;
                    end
                    else if (text_byte == CH_LBRACE)
                    begin
                        res_valid = 1'b1;
                        res_cause = CAUSE_BRACE;
                    end
                    else if (text_byte == CH_EQUALS)
                    begin
                        res_valid = 1'b1;
                        res_cause = CAUSE_EQUALS;
                    end
                    else if (text_byte == CH_NEWLINE)
                    begin
                        res_valid    = 1'b1;
                        res_accepted = 1'b1;
                        res_cause    = CAUSE_NEWLINE;
                    end
                    else if (text_byte == CH_SLASH)
                    begin
                        slash_pending_next = 1'b1;
                    end
                    else
                    begin
                        prev_bs_next = (text_byte == CH_BACKSLASH);
                    end
                end
                KIND_PARENS, KIND_BRACES:
                begin
                    priority if (text_byte == CH_LPAREN)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_PARENS;
                    end
                    else if (text_byte == CH_LBRACE)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_BRACES;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_QUOTES;
                    end
                    else if ((top_kind == KIND_PARENS && text_byte == CH_RPAREN) ||
                             (top_kind == KIND_BRACES && text_byte == CH_RBRACE))
                    begin
                        // The closing byte is consumed by the pop.
                        pop_want     = 1'b1;
                        prev_bs_next = 1'b0;
                    end
                    else
                    begin
                        prev_bs_next = (text_byte == CH_BACKSLASH);
                    end
                end
                KIND_QUOTES:
                begin
                    priority if (text_byte == CH_LPAREN)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_PARENS;
                    end
                    else if (text_byte == CH_LBRACE)
                    begin
                        push_want = 1'b1;
                        push_kind = KIND_BRACES;
                    end
                    else if (text_byte == CH_QUOTE && !prev_bs_reg)
                    begin
                        pop_want     = 1'b1;
                        prev_bs_next = 1'b0;
                    end
                    else
                    begin
                        // A doubled backslash escapes itself.
                        prev_bs_next = (text_byte == CH_BACKSLASH) && !prev_bs_reg;
                    end
                end
                default:
                begin
                    prev_bs_next = prev_bs_reg;
                end
            endcase

            if (push_want && stack_full)
            begin
                res_valid = 1'b1;
                res_cause = CAUSE_OVERFLOW;
            end
        end

        // A verdict returns everything to the reset state.
        if (res_valid)
        begin
            slash_pending_next = 1'b0;
            prev_bs_next       = 1'b0;
        end
    end

    assign shift.push = text_fire && push_want && !res_valid;
    assign shift.pop  = text_fire && pop_want;

    always_comb
    begin
        priority if (text_fire && res_valid)
        begin
            depth_next = '0;
        end
        else if (shift.push)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
        else if (shift.pop)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg         <= '0;
            slash_pending_reg <= 1'b0;
            prev_bs_reg       <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (text_fire)
            begin
                slash_pending_reg <= slash_pending_next;
                prev_bs_reg       <= prev_bs_next;
            end
        end
    end

    // The stack: a row of cells that shift together on a push or a pop.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            dnc_kind_t upper;
            dnc_kind_t lower;

            if (gi == 0)
            begin : g_first
                assign upper = push_kind;
            end
            else
            begin : g_inner_up
                assign upper = cell_kind[gi-1];
            end

            if (gi == NUM_CELLS - 1)
            begin : g_last
                assign lower = KIND_NONE;
            end
            else
            begin : g_inner_down
                assign lower = cell_kind[gi+1];
            end

            dnc_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .upper_kind (upper),
                .lower_kind (lower),
                .kind       (cell_kind[gi])
            );
        end
    endgenerate

    // Output register with a one-entry skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= text_fire && res_valid;
                end
            end
            else if (text_fire && res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                accepted_reg <= skid_accepted_reg;
                cause_reg    <= skid_cause_reg;
            end
            else if (text_fire && res_valid)
            begin
                accepted_reg <= res_accepted;
                cause_reg    <= res_cause;
            end
        end
        else if (text_fire && res_valid)
        begin
            skid_accepted_reg <= res_accepted;
            skid_cause_reg    <= res_cause;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign accepted      = accepted_reg;
    assign cause         = cause_reg;

    // The nesting depth never passes the last usable stack level.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
    else $error("nesting depth beyond the stack");

    // A verdict leaves the scanner in its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (text_fire && res_valid) |=>
            (depth_reg == '0 && !slash_pending_reg && !prev_bs_reg))
    else $error("state not cleared after a verdict");

    // A pending slash exists only at top level.
    assert property (@(posedge clk) disable iff (!rst_n)
        slash_pending_reg |-> (depth_reg == '0))
    else $error("slash pending inside a nesting level");

    // The skid register fills only behind a held output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid register holds a verdict ahead of the output");

    // Push and pop never happen in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(shift.push && shift.pop))
    else $error("stack pushed and popped together");

endmodule
